>>> src/qats_pkg.sv
`default_nettype none
package qats_pkg;

  // register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [1:0] REG_RATE_GAIN     = 2'd1;
  localparam logic [1:0] REG_ATTITUDE_GAIN = 2'd2;
  localparam logic [1:0] REG_TARGET_TERM   = 2'd3;

  localparam logic signed [17:0] TARGET_RESET = 18'sd25723;
  localparam logic signed [17:0] QUAT_ONE     = 18'sd16384;
  localparam logic signed [17:0] Q_MAX        = 18'sd131071;
  localparam logic signed [17:0] Q_MIN        = -18'sd131072;
  // 3.0 in Q.28
  localparam logic signed [55:0] K_THREE      = 56'sd805306368;

  localparam logic [4:0] LAST_STEP = 5'd30;

  typedef struct packed {
    logic        [15:0] dt;
    logic signed [15:0] kr;
    logic signed [15:0] ka;
    logic signed [17:0] tgt;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_RX, OP_RY, OP_RZ, OP_DT,
    OP_P0, OP_P1, OP_P2, OP_P3,
    OP_R0, OP_R1, OP_R2, OP_R3,
    OP_Q0, OP_Q3, OP_KR, OP_KA, OP_TGT, OP_ONE, OP_DLO, OP_DHI
  } opnd_t;

  typedef enum logic [1:0] {BASE_ZERO, BASE_ACC, BASE_K3} base_t;
  typedef enum logic [1:0] {SH_0, SH_14, SH_16, SH_18} shift_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_P1, DST_P2, DST_P3, DST_P0,
    DST_Q0, DST_Q1, DST_Q2, DST_Q3, DST_DIFF
  } dest_t;

  typedef struct packed {
    logic   mac;
    opnd_t  a;
    opnd_t  b;
    base_t  base;
    logic   neg;
    shift_t sh;
    dest_t  dest;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic load;    // capture input word
    logic commit;  // result done, R <= Q
  } cmd_t;

  typedef struct packed {
    logic               plus;
    logic               minus;
    logic signed [17:0] q0;
    logic signed [17:0] q1;
    logic signed [17:0] q2;
    logic signed [17:0] q3;
  } dp_stat_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

  localparam uop_t UOP_NOP = '{mac: 1'b0, a: OP_NONE, b: OP_NONE, base: BASE_ZERO,
                               neg: 1'b0, sh: SH_0, dest: DST_NONE};

  function automatic uop_t mk(opnd_t a, opnd_t b, base_t base, logic neg,
                              shift_t sh, dest_t dest);
    uop_t u;
    u.mac  = 1'b1;
    u.a    = a;
    u.b    = b;
    u.base = base;
    u.neg  = neg;
    u.sh   = sh;
    u.dest = dest;
    return u;
  endfunction

  // microprogram: one multiply-accumulate per step; a stored result passes
  // the product register and the accumulate stage before a later step can read it
  function automatic uop_t uop_at(logic [4:0] step);
    uop_t u;
    u = UOP_NOP;
    unique case (step)
      5'd0:  u = mk(OP_RX, OP_DT, BASE_ZERO, 1'b0, SH_0, DST_P1);
      5'd1:  u = mk(OP_RY, OP_DT, BASE_ZERO, 1'b0, SH_0, DST_P2);
      5'd2:  u = mk(OP_RZ, OP_DT, BASE_ZERO, 1'b0, SH_0, DST_P3);
      5'd3:  u = mk(OP_P1, OP_P1, BASE_K3,   1'b1, SH_0, DST_NONE);
      5'd4:  u = mk(OP_P2, OP_P2, BASE_ACC,  1'b1, SH_0, DST_NONE);
      5'd5:  u = mk(OP_P3, OP_P3, BASE_ACC,  1'b1, SH_0, DST_NONE);
      5'd6:  u = mk(OP_R0, OP_R0, BASE_ACC,  1'b1, SH_0, DST_NONE);
      5'd7:  u = mk(OP_R1, OP_R1, BASE_ACC,  1'b1, SH_0, DST_NONE);
      5'd8:  u = mk(OP_R2, OP_R2, BASE_ACC,  1'b1, SH_0, DST_NONE);
      5'd9:  u = mk(OP_R3, OP_R3, BASE_ACC,  1'b1, SH_0, DST_P0);
      5'd10: u = mk(OP_R1, OP_P1, BASE_ZERO, 1'b1, SH_0, DST_NONE);
      5'd11: u = mk(OP_R2, OP_P2, BASE_ACC,  1'b1, SH_0, DST_NONE);
      5'd12: u = mk(OP_R0, OP_P0, BASE_ACC,  1'b0, SH_0, DST_NONE);
      5'd13: u = mk(OP_R3, OP_P3, BASE_ACC,  1'b1, SH_0, DST_Q0);
      5'd14: u = mk(OP_R0, OP_P1, BASE_ZERO, 1'b0, SH_0, DST_NONE);
      5'd15: u = mk(OP_R1, OP_P0, BASE_ACC,  1'b0, SH_0, DST_NONE);
      5'd16: u = mk(OP_R2, OP_P3, BASE_ACC,  1'b0, SH_0, DST_NONE);
      5'd17: u = mk(OP_R3, OP_P2, BASE_ACC,  1'b1, SH_0, DST_Q1);
      5'd18: u = mk(OP_R0, OP_P2, BASE_ZERO, 1'b0, SH_0, DST_NONE);
      5'd19: u = mk(OP_R2, OP_P0, BASE_ACC,  1'b0, SH_0, DST_NONE);
      5'd20: u = mk(OP_R3, OP_P1, BASE_ACC,  1'b0, SH_0, DST_NONE);
      5'd21: u = mk(OP_R1, OP_P3, BASE_ACC,  1'b1, SH_0, DST_Q2);
      5'd22: u = mk(OP_R0, OP_P3, BASE_ZERO, 1'b0, SH_0, DST_NONE);
      5'd23: u = mk(OP_R3, OP_P0, BASE_ACC,  1'b0, SH_0, DST_NONE);
      5'd24: u = mk(OP_R1, OP_P2, BASE_ACC,  1'b0, SH_0, DST_NONE);
      5'd25: u = mk(OP_R2, OP_P1, BASE_ACC,  1'b1, SH_0, DST_Q3);
      5'd26: u = mk(OP_TGT, OP_ONE, BASE_ZERO, 1'b1, SH_14, DST_NONE);
      5'd27: u = mk(OP_Q0, OP_Q3, BASE_ACC,  1'b0, SH_0, DST_DIFF);
      5'd28: u = mk(OP_KR, OP_RZ, BASE_ZERO, 1'b0, SH_16, DST_NONE);
      5'd29: u = mk(OP_KA, OP_DLO, BASE_ACC, 1'b0, SH_0, DST_NONE);
      5'd30: u = mk(OP_KA, OP_DHI, BASE_ACC, 1'b0, SH_18, DST_NONE);
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

  function automatic logic signed [17:0] sat18(logic signed [55:0] v);
    logic signed [17:0] r;
    if (v > 56'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 56'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/qats_ctrl.sv
`default_nettype none
module qats_ctrl
  import qats_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic out_free,
  output cmd_t      cmd,
  output logic      busy
);

  state_t     state, state_next;
  logic [4:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == LAST_STEP) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.uop    = UOP_NOP;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_RUN:   cmd.uop = uop_at(step);
      ST_DRAIN: cmd.uop = UOP_NOP;
      ST_DONE:  cmd.commit = out_free;
      default:  cmd.uop = UOP_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> src/qats_dp.sv
`default_nettype none
module qats_dp
  import qats_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire cfg_t               cfg,
  input  wire logic signed [15:0] rate_x,
  input  wire logic signed [15:0] rate_y,
  input  wire logic signed [15:0] rate_z,
  output dp_stat_t                stat
);

  logic signed [15:0] rx, ry, rz;
  logic signed [17:0] p0, p1, p2, p3;
  logic signed [17:0] r0, r1, r2, r3;
  logic signed [17:0] q0, q1, q2, q3;
  logic signed [36:0] diff;
  logic signed [37:0] prod;
  logic signed [55:0] acc, acc_next;
  uop_t               uop_d;

  logic signed [18:0] opa, opb;
  logic signed [37:0] mult;
  logic signed [55:0] term, base_val;
  logic signed [55:0] sh15, sh14;

  function automatic logic signed [18:0] pick(opnd_t s);
    logic signed [18:0] v;
    unique case (s)
      OP_RX:   v = 19'(rx);
      OP_RY:   v = 19'(ry);
      OP_RZ:   v = 19'(rz);
      OP_DT:   v = {3'b000, cfg.dt};
      OP_P0:   v = 19'(p0);
      OP_P1:   v = 19'(p1);
      OP_P2:   v = 19'(p2);
      OP_P3:   v = 19'(p3);
      OP_R0:   v = 19'(r0);
      OP_R1:   v = 19'(r1);
      OP_R2:   v = 19'(r2);
      OP_R3:   v = 19'(r3);
      OP_Q0:   v = 19'(q0);
      OP_Q3:   v = 19'(q3);
      OP_KR:   v = 19'(cfg.kr);
      OP_KA:   v = 19'(cfg.ka);
      OP_TGT:  v = 19'(cfg.tgt);
      OP_ONE:  v = 19'sd1;
      OP_DLO:  v = {1'b0, diff[17:0]};
      OP_DHI:  v = diff[36:18];
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(cmd.uop.a);
    opb = pick(cmd.uop.b);
  end

  assign mult = opa * opb;

  // accumulate stage works on the product of the previous step
  always_comb begin
    unique case (uop_d.sh)
      SH_0:    term = 56'(prod);
      SH_14:   term = 56'(prod) <<< 14;
      SH_16:   term = 56'(prod) <<< 16;
      SH_18:   term = 56'(prod) <<< 18;
      default: term = 56'(prod);
    endcase
    unique case (uop_d.base)
      BASE_ZERO: base_val = '0;
      BASE_ACC:  base_val = acc;
      BASE_K3:   base_val = K_THREE;
      default:   base_val = '0;
    endcase
    acc_next = uop_d.neg ? base_val - term : base_val + term;
    sh15     = acc_next >>> 15;
    sh14     = acc_next >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uop_d <= UOP_NOP;
      r0    <= QUAT_ONE;
      r1    <= '0;
      r2    <= '0;
      r3    <= '0;
    end else begin
      uop_d <= cmd.uop;
      if (cmd.commit) begin
        r0 <= q0;
        r1 <= q1;
        r2 <= q2;
        r3 <= q3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx <= rate_x;
      ry <= rate_y;
      rz <= rate_z;
    end
    prod <= mult;
    if (uop_d.mac) begin
      acc <= acc_next;
      unique case (uop_d.dest)
        DST_NONE: ;
        DST_P1:   p1 <= sh15[17:0];
        DST_P2:   p2 <= sh15[17:0];
        DST_P3:   p3 <= sh15[17:0];
        DST_P0:   p0 <= sat18(sh15);
        DST_Q0:   q0 <= sat18(sh14);
        DST_Q1:   q1 <= sat18(sh14);
        DST_Q2:   q2 <= sat18(sh14);
        DST_Q3:   q3 <= sat18(sh14);
        DST_DIFF: diff <= acc_next[36:0];
        default: ;
      endcase
    end
  end

  // acc ends as -u3
  assign stat.plus  = acc[55];
  assign stat.minus = !acc[55] && (acc != '0);
  assign stat.q0    = q0;
  assign stat.q1    = q1;
  assign stat.q2    = q2;
  assign stat.q3    = q3;

endmodule
`default_nettype wire

>>> src/quaternion_attitude_torque_sign_top.sv
// Quaternion attitude propagation with a bang-bang z coil command.
// Input channel (in_valid / in_stall): one gyro word, rate_x/y/z in Q4.12.
// Output channel (out_valid / out_stall): one result word per input word,
//   the new attitude quaternion quat_w..quat_z (Q3.14, saturated) and the
//   z coil pair coil_z_plus / coil_z_minus from the sign of the torque value.
// Config: APB-style, four 32-bit word registers at 0x0 time_step,
//   0x4 rate_gain, 0x8 attitude_gain, 0xC target_term. pready is tied high.
//   Write only while the block is idle.
// Sequence: one shared 19x19 multiplier runs a 31-step microprogram, then a
//   drain state accumulates the last product and a finish state commits the
//   result word to the output register. A new input word is taken only once
//   the block is back in idle, after the result of the last one is committed.
// in_stall is high while a word is being worked on. The output register
//   decouples the sides: a new word is taken while the last result waits;
//   if that result is still stalled when the next one finishes, the block
//   holds in its finish state until out_stall drops.
// Reset (rst, synchronous): stored attitude is the identity, registers take
//   their reset values, no result is pending.
`default_nettype none
module quaternion_attitude_torque_sign_top
  import qats_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // input words
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] rate_x,
  input  wire logic signed [15:0] rate_y,
  input  wire logic signed [15:0] rate_z,
  // result words
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    coil_z_plus,
  output logic                    coil_z_minus,
  output logic signed [17:0]      quat_w,
  output logic signed [17:0]      quat_x,
  output logic signed [17:0]      quat_y,
  output logic signed [17:0]      quat_z,
  // config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t     cfg;
  cmd_t     cmd;
  dp_stat_t stat;
  logic     busy;
  logic     start;
  logic     out_free;
  logic     cfg_wr;

  // ---------------- configuration registers ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dt  <= '0;
      cfg.kr  <= '0;
      cfg.ka  <= '0;
      cfg.tgt <= TARGET_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TIME_STEP:     cfg.dt  <= pwdata[15:0];
        REG_RATE_GAIN:     cfg.kr  <= pwdata[15:0];
        REG_ATTITUDE_GAIN: cfg.ka  <= pwdata[15:0];
        REG_TARGET_TERM:   cfg.tgt <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TIME_STEP:     prdata = {16'b0, cfg.dt};
      REG_RATE_GAIN:     prdata = {16'b0, cfg.kr};
      REG_ATTITUDE_GAIN: prdata = {16'b0, cfg.ka};
      REG_TARGET_TERM:   prdata = {14'b0, cfg.tgt};
      default:           prdata = '0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign in_stall = busy;
  assign start    = in_valid && !busy;
  // output register may be overwritten this cycle
  assign out_free = !out_valid || !out_stall;

  qats_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .cmd      (cmd),
    .busy     (busy)
  );

  qats_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .rate_x (rate_x),
    .rate_y (rate_y),
    .rate_z (rate_z),
    .stat   (stat)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      coil_z_plus  <= stat.plus;
      coil_z_minus <= stat.minus;
      quat_w       <= stat.q0;
      quat_x       <= stat.q1;
      quat_y       <= stat.q2;
      quat_z       <= stat.q3;
    end
  end

  // ---------------- assertions ----------------
  // a taken word keeps the input side closed next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a result never overwrites one that is still stalled
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without valid result");

  // coil pair is never driven both ways while a result is valid
  a_coil_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(coil_z_plus && coil_z_minus))
    else $error("both coil outputs on");

endmodule
`default_nettype wire
